>>> hdl/fcsf_pkg.sv
// ----------------------------------------------------------------------------
// fcsf_pkg
// Types, constants and the CRC byte update for the four-channel scope framer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsf_pkg;

	localparam int unsigned CHAN_W      = 16;
	localparam int unsigned NUM_CHAN    = 4;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned DATA_BYTES  = 8;
	localparam int unsigned FRAME_BYTES = 10;
	localparam int unsigned IDX_W       = 4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [IDX_W-1:0] IDX_FIRST   = 4'd0;
	localparam logic [IDX_W-1:0] IDX_CRC_LO  = 4'd8;
	localparam logic [IDX_W-1:0] IDX_CRC_HI  = 4'd9;

	typedef struct packed {
		logic [CHAN_W-1:0] chan3;
		logic [CHAN_W-1:0] chan2;
		logic [CHAN_W-1:0] chan1;
		logic [CHAN_W-1:0] chan0;
	} item_t;

	typedef struct packed {
		logic valid;
	} buf_ctl_t;

	// reflected CRC-16 update by one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
			input logic [BYTE_W-1:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < BYTE_W; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hdl/fcsf_in_reg.sv
// ----------------------------------------------------------------------------
// fcsf_in_reg
// One-item input register; holds the next item while a frame is still sent.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsf_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire fcsf_pkg::item_t in_item,
	input  wire logic            take,
	output fcsf_pkg::buf_ctl_t   ctl,
	output fcsf_pkg::item_t      item
);
	import fcsf_pkg::*;

	logic  valid_q;
	item_t item_q;
	logic  xfer;

	assign in_stall = valid_q && !take;
	assign xfer     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (xfer) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			item_q <= in_item;
		end
	end

	assign ctl.valid = valid_q;
	assign item      = item_q;

endmodule

`default_nettype wire

>>> hdl/fcsf_serializer.sv
// ----------------------------------------------------------------------------
// fcsf_serializer
// Sends eight data bytes low byte first, then the running CRC, one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsf_serializer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fcsf_pkg::buf_ctl_t buf_ctl,
	input  wire fcsf_pkg::item_t item,
	output logic                 take,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           frame_byte,
	output logic                 last
);
	import fcsf_pkg::*;

	logic                busy_q;
	logic [IDX_W-1:0]    idx_q;
	logic [63:0]         data_q;
	logic [15:0]         crc_q;
	logic                xfer;
	logic                done;

	assign out_valid = busy_q;
	assign xfer      = busy_q && !out_stall;
	assign last      = (idx_q == IDX_CRC_HI);
	assign done      = xfer && last;
	assign take      = buf_ctl.valid && (!busy_q || done);

	always_comb begin
		if (idx_q == IDX_CRC_LO) begin
			frame_byte = crc_q[7:0];
		end else if (idx_q == IDX_CRC_HI) begin
			frame_byte = crc_q[15:8];
		end else begin
			frame_byte = data_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= IDX_FIRST;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= IDX_FIRST;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (xfer) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= item;
			crc_q  <= CRC_INIT;
		end else if (xfer && (idx_q < IDX_CRC_LO)) begin
			data_q <= {8'h00, data_q[63:8]};
			crc_q  <= crc_byte(crc_q, data_q[7:0]);
		end
	end

endmodule

`default_nettype wire

>>> hdl/four_channel_scope_framer_crc16.sv
// ----------------------------------------------------------------------------
// four_channel_scope_framer_crc16
// Frames four 16-bit channel values as ten bytes with a CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_stall | chan0, chan1, chan2, chan3
//  out     | out_valid/out_stall | frame_byte, last
//
//  Each item yields ten byte transfers, one per cycle when out_stall is low,
//  so the sustained item rate is set by the byte output.
//  The CRC is updated by one byte per data transfer.
//  One further item is held in the input register while a frame is sent;
//  the next frame starts in the cycle after the last byte of the previous.
//  Reset clears the handshake state only; no frame is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_scope_framer_crc16 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] chan0,
	input  wire logic [15:0] chan1,
	input  wire logic [15:0] chan2,
	input  wire logic [15:0] chan3,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       frame_byte,
	output logic             last
);
	import fcsf_pkg::*;

	item_t    in_item;
	item_t    item;
	buf_ctl_t buf_ctl;
	logic     take;

	assign in_item.chan0 = chan0;
	assign in_item.chan1 = chan1;
	assign in_item.chan2 = chan2;
	assign in_item.chan3 = chan3;

	fcsf_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (take),
		.ctl      (buf_ctl),
		.item     (item)
	);

	fcsf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.buf_ctl    (buf_ctl),
		.item       (item),
		.take       (take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last       (last)
	);

	// the input side only waits while a frame is going out
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && buf_ctl.valid))
		else $error("input stalled with idle serializer");

	// a frame does not end before its tenth byte
	a_frame_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> out_valid)
		else $error("frame cut short");

	// a frame never starts on its last byte
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !last)
		else $error("frame started at last byte");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for the four-channel scope framer. Each item sent in is turned
// into its expected ten-byte frame (data bytes, then the CRC-16/MODBUS
// trailer, with the last flag on the final byte). Every byte transfer on the
// output is compared with the oldest expected byte. A short list of edge
// patterns comes first, then random items. Both sides idle at random, with a
// long stretch where neither idles.
// ----------------------------------------------------------------------------
module tb;
	import fcsf_pkg::*;

	typedef struct packed {
		logic       is_last;
		logic [7:0] value;
	} frame_out_t;

	localparam int unsigned RANDOM_ITEMS = 460;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned SETTLE       = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] chan0, chan1, chan2, chan3;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  frame_byte;
	logic        last;

	frame_out_t  pending_bytes[$];
	frame_out_t  want;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned bytes_seen = 0;
	logic        steady = 1'b0;

	// {chan3, chan2, chan1, chan0}
	item_t edge_rows [14] = '{
		64'h0000_0000_0000_0000,
		64'hFFFF_FFFF_FFFF_FFFF,
		64'hFFFF_0000_FFFF_0000,
		64'h0000_FFFF_0000_FFFF,
		64'h00FF_00FF_00FF_00FF,
		64'hFF00_FF00_FF00_FF00,
		64'h8000_8000_8000_8000,
		64'h0001_0001_0001_0001,
		64'h5555_5555_5555_5555,
		64'hAAAA_AAAA_AAAA_AAAA,
		64'h0004_0003_0002_0001,
		64'h1234_5678_9ABC_DEF0,
		64'h0000_0000_0000_0000,
		64'hFFFF_FFFF_FFFF_FFFF
	};

	four_channel_scope_framer_crc16 uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.chan0      (chan0),
		.chan1      (chan1),
		.chan2      (chan2),
		.chan3      (chan3),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reflected CRC, one data bit shifted in at a time, LSB first
	function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < BYTE_W; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void queue_frame(input item_t it);
		logic [63:0] flat;
		logic [7:0]  bytes [10];
		logic [15:0] crc;
		flat = it;
		crc  = CRC_INIT;
		for (int k = 0; k < 8; k++) begin
			bytes[k] = flat[8*k +: 8];
			crc      = crc_after(crc, bytes[k]);
		end
		bytes[8] = crc[7:0];
		bytes[9] = crc[15:8];
		for (int k = 0; k < 10; k++) begin
			pending_bytes.push_back({k == 9, bytes[k]});
		end
	endfunction

	function automatic logic [15:0] pick_chan();
		logic [15:0] v;
		case ($urandom_range(9))
			0: v = 16'h0000;
			1: v = 16'hFFFF;
			2: v = 16'h1 << $urandom_range(15);
			3: v = ~(16'h1 << $urandom_range(15));
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_item(input item_t it);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		chan0    <= it.chan0;
		chan1    <= it.chan1;
		chan2    <= it.chan2;
		chan3    <= it.chan3;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		queue_frame(it);
	endtask

	initial out_stall = 1'b0;

	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 20);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				if (errors < 10) begin
					$display("byte %0d: unexpected transfer, byte %02h last %b",
						bytes_seen, frame_byte, last);
				end
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (want.value !== frame_byte || want.is_last !== last) begin
					if (errors < 10) begin
						$display("byte %0d: expected %02h last %b, got %02h last %b",
							bytes_seen, want.value, want.is_last, frame_byte, last);
					end
					errors++;
				end
			end
			bytes_seen++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		chan0    = 16'h0000;
		chan1    = 16'h0000;
		chan2    = 16'h0000;
		chan3    = 16'h0000;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (edge_rows[i]) begin
			send_item(edge_rows[i]);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 150 && n < 250);
			send_item({pick_chan(), pick_chan(), pick_chan(), pick_chan()});
		end
		steady = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/fcsf_pkg.sv
hdl/fcsf_in_reg.sv
hdl/fcsf_serializer.sv
hdl/four_channel_scope_framer_crc16.sv
bench/tb.sv
